// ----- hw/rtl/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Used by the front decoder, the entry queue, the back end and the top level.
// No dependencies.
package u8u16_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StBadLead    = 3'd1,
    StIncomplete = 3'd2,
    StInvalid    = 3'd3,
    StOverlong   = 3'd4
  } status_e;

  localparam int unsigned CpWidth      = 21;
  localparam int unsigned DataWidth    = 20;
  localparam int unsigned OffsetWidth  = 32;
  localparam int unsigned UnitWidth    = 16;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [CpWidth-1:0] BmpMax       = 21'h00FFFF;
  localparam logic [CpWidth-1:0] CpMax        = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrogateLo  = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrogateHi  = 21'h00DFFF;
  localparam logic [CpWidth-1:0] OneByteMax   = 21'h00007F;
  localparam logic [CpWidth-1:0] TwoByteMax   = 21'h0007FF;
  localparam logic [CpWidth-1:0] SuppBase     = 21'h010000;
  localparam logic [5:0]         LeadPrefix   = 6'b110110;
  localparam logic [5:0]         TrailPrefix  = 6'b110111;

  // One classified entry handed from the front to the back end.
  // For a single unit, data holds the unit in its low 16 bits; for a pair,
  // data holds the code point less 0x10000.
  typedef struct packed {
    logic                   pair;
    logic [DataWidth-1:0]   data;
    status_e                status;
    logic [OffsetWidth-1:0] offset;
  } entry_t;

endpackage

// ----- hw/rtl/u8u16_front.sv -----
// Front decoder: takes one UTF-8 byte per beat and classifies sequences.
// Emits one entry per completed sequence or error into the entry queue.
// Depends on u8u16_pkg.
module u8u16_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            byte_value_i,
  input  logic                  stream_end_i,
  output logic                  push_o,
  output u8u16_pkg::entry_t     entry_o
);

  logic [u8u16_pkg::CpWidth-1:0]     partial_q, partial_d;
  logic [1:0]                        remaining_q, remaining_d;
  logic [2:0]                        seq_len_q, seq_len_d;
  logic [u8u16_pkg::OffsetWidth-1:0] byte_pos_q, byte_pos_d;
  logic [u8u16_pkg::OffsetWidth-1:0] seq_start_q, seq_start_d;

  logic                          idle;
  logic [u8u16_pkg::CpWidth-1:0] cp;
  logic [u8u16_pkg::CpWidth-1:0] supp;
  logic [2:0]                    enc_len;
  logic                          err;
  logic                          done;
  u8u16_pkg::status_e            err_status;

  assign idle = (remaining_q == 2'd0);

  // Decode the byte against the open sequence
  always_comb begin
    partial_d   = partial_q;
    remaining_d = remaining_q;
    seq_len_d   = seq_len_q;
    seq_start_d = seq_start_q;
    err         = 1'b0;
    done        = 1'b0;
    err_status  = u8u16_pkg::StOk;
    if (idle) begin
      seq_start_d = byte_pos_q;
      if (byte_value_i[7] == 1'b0) begin
        seq_len_d   = 3'd1;
        remaining_d = 2'd0;
        partial_d   = {13'd0, byte_value_i};
      end else if (byte_value_i[7:5] == 3'b110) begin
        seq_len_d   = 3'd2;
        remaining_d = 2'd1;
        partial_d   = {16'd0, byte_value_i[4:0]};
      end else if (byte_value_i[7:4] == 4'b1110) begin
        seq_len_d   = 3'd3;
        remaining_d = 2'd2;
        partial_d   = {17'd0, byte_value_i[3:0]};
      end else if (byte_value_i[7:3] == 5'b11110) begin
        seq_len_d   = 3'd4;
        remaining_d = 2'd3;
        partial_d   = {18'd0, byte_value_i[2:0]};
      end else begin
        err        = 1'b1;
        err_status = u8u16_pkg::StBadLead;
      end
    end else if (byte_value_i[7:6] != 2'b10) begin
      err        = 1'b1;
      err_status = u8u16_pkg::StIncomplete;
    end else begin
      partial_d   = {partial_q[14:0], byte_value_i[5:0]};
      remaining_d = remaining_q - 2'd1;
    end
    // Open sequence cut off by stream end
    if (!err && remaining_d != 2'd0 && stream_end_i) begin
      err        = 1'b1;
      err_status = u8u16_pkg::StIncomplete;
    end
    if (!err && remaining_d == 2'd0) begin
      done = 1'b1;
    end
  end

  assign cp   = partial_d;
  assign supp = cp - u8u16_pkg::SuppBase;

  // Length of the shortest form of the code point
  always_comb begin
    if (cp <= u8u16_pkg::OneByteMax) begin
      enc_len = 3'd1;
    end else if (cp <= u8u16_pkg::TwoByteMax) begin
      enc_len = 3'd2;
    end else if (cp <= u8u16_pkg::BmpMax) begin
      enc_len = 3'd3;
    end else begin
      enc_len = 3'd4;
    end
  end

  // Build the queue entry
  always_comb begin
    entry_o.pair   = 1'b0;
    entry_o.data   = '0;
    entry_o.status = err_status;
    entry_o.offset = seq_start_d;
    if (done) begin
      if ((cp >= u8u16_pkg::SurrogateLo && cp <= u8u16_pkg::SurrogateHi) ||
          cp > u8u16_pkg::CpMax) begin
        entry_o.status = u8u16_pkg::StInvalid;
      end else if (enc_len != seq_len_d) begin
        entry_o.status = u8u16_pkg::StOverlong;
      end else begin
        entry_o.status = u8u16_pkg::StOk;
        entry_o.offset = '0;
        if (cp <= u8u16_pkg::BmpMax) begin
          entry_o.data = {4'd0, cp[15:0]};
        end else begin
          entry_o.pair = 1'b1;
          entry_o.data = supp[u8u16_pkg::DataWidth-1:0];
        end
      end
    end
  end

  assign push_o = accept_i && (err || done);

  // Advance decoder state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      remaining_q <= '0;
      seq_len_q   <= '0;
      byte_pos_q  <= '0;
      seq_start_q <= '0;
    end else if (accept_i) begin
      seq_start_q <= seq_start_d;
      if (err || done || stream_end_i) begin
        partial_q   <= '0;
        remaining_q <= '0;
        seq_len_q   <= '0;
      end else begin
        partial_q   <= partial_d;
        remaining_q <= remaining_d;
        seq_len_q   <= seq_len_d;
      end
      byte_pos_q <= byte_pos_d;
    end
  end

  assign byte_pos_d = stream_end_i ? '0 : byte_pos_q + 32'd1;

endmodule

// ----- hw/rtl/u8u16_fifo.sv -----
// Short entry queue between the front decoder and the back end.
// Depth set by the Depth parameter (at least 2). Depends on u8u16_pkg.
module u8u16_fifo #(
  parameter int unsigned Depth = u8u16_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8u16_pkg::entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output u8u16_pkg::entry_t entry_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  u8u16_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- hw/rtl/u8u16_back.sv -----
// Back end: expands queue entries into UTF-16 result beats.
// A supplementary code point gives a lead then a trail surrogate beat.
// Depends on u8u16_pkg.
module u8u16_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   empty_i,
  input  u8u16_pkg::entry_t                      entry_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [u8u16_pkg::UnitWidth-1:0]        code_unit_o,
  output logic [2:0]                             status_o,
  output logic [u8u16_pkg::OffsetWidth-1:0]      error_offset_o,
  output logic                                   last_of_run_o
);

  logic                                 valid_q;
  logic                                 trail_pend_q;
  logic [9:0]                           trail_q;
  logic [u8u16_pkg::UnitWidth-1:0]      unit_q;
  u8u16_pkg::status_e                   status_q;
  logic [u8u16_pkg::OffsetWidth-1:0]    offset_q;
  logic                                 last_q;
  logic                                 slot_free;

  assign slot_free = !valid_q || out_ready_i;
  assign pop_o     = slot_free && !trail_pend_q && !empty_i;

  // Load the output register with the next beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      trail_pend_q <= 1'b0;
      trail_q      <= '0;
      unit_q       <= '0;
      status_q     <= u8u16_pkg::StOk;
      offset_q     <= '0;
      last_q       <= 1'b0;
    end else if (slot_free) begin
      if (trail_pend_q) begin
        valid_q      <= 1'b1;
        trail_pend_q <= 1'b0;
        unit_q       <= {u8u16_pkg::TrailPrefix, trail_q};
        status_q     <= u8u16_pkg::StOk;
        offset_q     <= '0;
        last_q       <= 1'b1;
      end else if (!empty_i) begin
        valid_q  <= 1'b1;
        status_q <= entry_i.status;
        offset_q <= entry_i.offset;
        if (entry_i.pair) begin
          trail_pend_q <= 1'b1;
          trail_q      <= entry_i.data[9:0];
          unit_q       <= {u8u16_pkg::LeadPrefix, entry_i.data[19:10]};
          last_q       <= 1'b0;
        end else begin
          unit_q <= entry_i.data[u8u16_pkg::UnitWidth-1:0];
          last_q <= 1'b1;
        end
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign code_unit_o    = unit_q;
  assign status_o       = status_q;
  assign error_offset_o = offset_q;
  assign last_of_run_o  = last_q;

endmodule

// ----- hw/rtl/utf8_to_utf16_transcoder_unit.sv -----
// Channel | Handshake                  | Beat payload
// in      | in_valid_i / in_ready_o    | byte_value_i, stream_end_i
// out     | out_valid_o / out_ready_i  | code_unit_o, status_o, error_offset_o, last_of_run_o
//
// One byte is taken per cycle unless the entry queue between decoder and back end
// is full; each completed sequence or error is pushed to that queue, then loaded
// into the output register. A supplementary code point occupies that register
// as a lead then a trail surrogate beat; the queue absorbs this, and in_ready_o
// drops only when it is full. Reset (rst_ni low, asynchronous) empties the queue
// and returns the decoder to idle at stream offset 0. Depends on u8u16_pkg,
// u8u16_front, u8u16_fifo and u8u16_back.
module utf8_to_utf16_transcoder_unit #(
  parameter int unsigned QueueDepth = u8u16_pkg::QueueDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        byte_value_i,
  input  logic                              stream_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [u8u16_pkg::UnitWidth-1:0]   code_unit_o,
  output logic [2:0]                        status_o,
  output logic [u8u16_pkg::OffsetWidth-1:0] error_offset_o,
  output logic                              last_of_run_o
);

  logic              accept;
  logic              push, full, pop, empty;
  u8u16_pkg::entry_t push_entry, pop_entry;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  // Decode bytes into entries
  u8u16_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_value_i (byte_value_i),
    .stream_end_i (stream_end_i),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Hold entries between the two halves
  u8u16_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  // Expand entries into result beats
  u8u16_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_unit_o    (code_unit_o),
    .status_o       (status_o),
    .error_offset_o (error_offset_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

// ----- test/tb_utf8_to_utf16_transcoder_unit.sv -----
// Self-checking testbench for the UTF-8 to UTF-16 transcoder unit.
// It predicts every UTF-16 unit and error beat from the byte stream and compares them in order.
// Depends on u8u16_pkg and utf8_to_utf16_transcoder_unit.
module tb_utf8_to_utf16_transcoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 20;

  // One expected output beat
  typedef struct packed {
    logic [u8u16_pkg::UnitWidth-1:0]   code;
    u8u16_pkg::status_e                status;
    logic [u8u16_pkg::OffsetWidth-1:0] offset;
    logic                              last;
  } unit_beat_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_ready_o;
  logic [7:0]                        byte_value_i   = 8'h00;
  logic                              stream_end_i   = 1'b0;
  logic                              out_valid_o;
  logic                              out_ready_i    = 1'b0;
  logic [u8u16_pkg::UnitWidth-1:0]   code_unit_o;
  logic [2:0]                        status_o;
  logic [u8u16_pkg::OffsetWidth-1:0] error_offset_o;
  logic                              last_of_run_o;

  // Decoder state as the predictor sees it
  logic [20:0]            cp_acc    = '0;
  logic [1:0]             need_cont = '0;
  logic [2:0]             seq_len   = '0;
  logic [31:0]            byte_pos  = '0;
  logic [31:0]            lead_pos  = '0;

  unit_beat_t             units_due[$];
  logic [7:0]             seq_bytes[$];
  int unsigned            fail_count    = 0;
  int unsigned            send_idle_pct = 0;
  int unsigned            recv_idle_pct = 0;
  int unsigned            hold_req      = 0;
  int unsigned            hold_ack      = 0;
  int unsigned            hold_left     = 0;
  int unsigned            quiet_cycles  = 0;

  utf8_to_utf16_transcoder_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .stream_end_i   (stream_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_unit_o    (code_unit_o),
    .status_o       (status_o),
    .error_offset_o (error_offset_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Length of the shortest UTF-8 form of a code point
  function automatic int unsigned utf8_len(input logic [20:0] cp);
    if (cp <= 21'h00007F) return 1;
    if (cp <= 21'h0007FF) return 2;
    if (cp <= 21'h00FFFF) return 3;
    return 4;
  endfunction

  function automatic void expect_unit(input logic [u8u16_pkg::UnitWidth-1:0] code,
                                      input u8u16_pkg::status_e st,
                                      input logic [u8u16_pkg::OffsetWidth-1:0] offset,
                                      input logic last);
    unit_beat_t beat;
    beat.code   = code;
    beat.status = st;
    beat.offset = offset;
    beat.last   = last;
    units_due.insert(units_due.size(), beat);
  endfunction

  // Advance the decoder by one byte and queue the beats it produces
  function automatic void predict_units(input logic [7:0] b, input logic fin);
    logic [31:0] here;
    logic [19:0] supp;
    logic        fault;
    here     = byte_pos;
    fault    = 1'b0;
    byte_pos = byte_pos + 32'd1;
    if (need_cont == 2'd0) begin
      lead_pos = here;
      if (b < 8'h80) begin
        seq_len = 3'd1;
        cp_acc  = {13'd0, b};
      end else if (b >= 8'hC0 && b < 8'hE0) begin
        seq_len   = 3'd2;
        need_cont = 2'd1;
        cp_acc    = {16'd0, b[4:0]};
      end else if (b >= 8'hE0 && b < 8'hF0) begin
        seq_len   = 3'd3;
        need_cont = 2'd2;
        cp_acc    = {17'd0, b[3:0]};
      end else if (b >= 8'hF0 && b < 8'hF8) begin
        seq_len   = 3'd4;
        need_cont = 2'd3;
        cp_acc    = {18'd0, b[2:0]};
      end else begin
        expect_unit('0, u8u16_pkg::StBadLead, here, 1'b1);
        fault = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      // the offending byte is dropped, not taken as a new lead
      expect_unit('0, u8u16_pkg::StIncomplete, lead_pos, 1'b1);
      fault = 1'b1;
    end else begin
      cp_acc    = {cp_acc[14:0], b[5:0]};
      need_cont = need_cont - 2'd1;
    end

    if (!fault) begin
      if (need_cont != 2'd0) begin
        if (fin) expect_unit('0, u8u16_pkg::StIncomplete, lead_pos, 1'b1);
      end else if ((cp_acc >= 21'h00D800 && cp_acc <= 21'h00DFFF) || cp_acc > 21'h10FFFF) begin
        expect_unit('0, u8u16_pkg::StInvalid, lead_pos, 1'b1);
      end else if (utf8_len(cp_acc) != seq_len) begin
        expect_unit('0, u8u16_pkg::StOverlong, lead_pos, 1'b1);
      end else if (cp_acc <= 21'h00FFFF) begin
        expect_unit(cp_acc[15:0], u8u16_pkg::StOk, '0, 1'b1);
      end else begin
        supp = 20'(cp_acc - 21'h010000);
        expect_unit(16'hD800 + {6'd0, supp[19:10]}, u8u16_pkg::StOk, '0, 1'b0);
        expect_unit(16'hDC00 + {6'd0, supp[9:0]}, u8u16_pkg::StOk, '0, 1'b1);
      end
    end

    // close the sequence unless it is still open mid-stream
    if (fault || need_cont == 2'd0 || fin) begin
      cp_acc    = '0;
      need_cont = '0;
      seq_len   = '0;
    end
    if (fin) byte_pos = '0;
  endfunction

  task automatic check_unit();
    unit_beat_t want;
    if (units_due.size() == 0) begin
      $error("unexpected beat: code_unit %h status %0d error_offset %0d last_of_run %b",
             code_unit_o, status_o, error_offset_o, last_of_run_o);
      fail_count++;
    end else begin
      want = units_due.pop_front();
      if (code_unit_o !== want.code) begin
        $error("code_unit: expected %h, got %h", want.code, code_unit_o);
        fail_count++;
      end
      if (status_o !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status_o);
        fail_count++;
      end
      if (error_offset_o !== want.offset) begin
        $error("error_offset: expected %0d, got %0d", want.offset, error_offset_o);
        fail_count++;
      end
      if (last_of_run_o !== want.last) begin
        $error("last_of_run: expected %b, got %b", want.last, last_of_run_o);
        fail_count++;
      end
    end
  endtask

  // Predict on every accepted byte, then check every accepted result beat
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) predict_units(byte_value_i, stream_end_i);
    if (rst_ni && out_valid_o && out_ready_i) check_unit();
  end

  // Drive out_ready_i: random idling, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stop the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one byte, idling at random first, and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= b;
    stream_end_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and hold until every expected beat has come out
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    // let the predictor take the last accepted byte first
    @(posedge clk_i);
    while (units_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [20:0] pick_valid_cp(input int unsigned len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(32'h7F));
      2: cp = 21'($urandom_range(32'h7FF, 32'h80));
      3: begin
        cp = 21'($urandom_range(32'hFFFF, 32'h800));
        // steer clear of the surrogate block
        if (cp >= 21'h00D800 && cp <= 21'h00DFFF) cp = cp ^ 21'h004000;
      end
      default: cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
    endcase
    return cp;
  endfunction

  // Encode a code point in exactly len bytes, overlong or not
  function automatic void build_sequence(input logic [20:0] cp, input int unsigned len);
    seq_bytes.delete();
    case (len)
      1: seq_bytes.insert(seq_bytes.size(), {1'b0, cp[6:0]});
      2: begin
        seq_bytes.insert(seq_bytes.size(), {3'b110, cp[10:6]});
        seq_bytes.insert(seq_bytes.size(), {2'b10, cp[5:0]});
      end
      3: begin
        seq_bytes.insert(seq_bytes.size(), {4'b1110, cp[15:12]});
        seq_bytes.insert(seq_bytes.size(), {2'b10, cp[11:6]});
        seq_bytes.insert(seq_bytes.size(), {2'b10, cp[5:0]});
      end
      default: begin
        seq_bytes.insert(seq_bytes.size(), {5'b11110, cp[20:18]});
        seq_bytes.insert(seq_bytes.size(), {2'b10, cp[17:12]});
        seq_bytes.insert(seq_bytes.size(), {2'b10, cp[11:6]});
        seq_bytes.insert(seq_bytes.size(), {2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Mostly well-formed sequences, with broken ones and raw noise mixed in
  task automatic send_random_stream(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int          end_at;
    logic [20:0] cp;
    logic        cut;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      cut  = 1'b0;
      if (pick < 75) begin
        len = (pick < 20) ? 1 : (pick < 40) ? 2 : (pick < 60) ? 3 : 4;
        build_sequence(pick_valid_cp(len), len);
      end else if (pick < 80) begin
        case ($urandom_range(9))
          0:       cp = 21'h000000;
          1:       cp = 21'h00007F;
          2:       cp = 21'h000080;
          3:       cp = 21'h0007FF;
          4:       cp = 21'h000800;
          5:       cp = 21'h00D7FF;
          6:       cp = 21'h00E000;
          7:       cp = 21'h00FFFF;
          8:       cp = 21'h010000;
          default: cp = 21'h10FFFF;
        endcase
        build_sequence(cp, utf8_len(cp));
      end else if (pick < 84) begin
        len = $urandom_range(4, 2);
        cp  = 21'($urandom_range(len == 2 ? 32'h7F : len == 3 ? 32'h7FF : 32'hFFFF));
        build_sequence(cp, len);
      end else if (pick < 87) begin
        build_sequence(21'($urandom_range(32'hDFFF, 32'hD800)), 3);
      end else if (pick < 90) begin
        build_sequence(21'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
      end else if (pick < 95) begin
        // truncated sequence
        len = $urandom_range(4, 2);
        build_sequence(pick_valid_cp(len), len);
        repeat ($urandom_range(len - 1, 1)) void'(seq_bytes.pop_back());
        cut = 1'b1;
      end else begin
        seq_bytes.delete();
        repeat ($urandom_range(3, 1)) begin
          seq_bytes.insert(seq_bytes.size(), 8'($urandom_range(255)));
        end
      end

      end_at = -1;
      if ($urandom_range(24) == 0 || (cut && $urandom_range(1) == 1)) begin
        end_at = seq_bytes.size() - 1;
      end else if ($urandom_range(99) == 0) begin
        end_at = $urandom_range(seq_bytes.size() - 1);
      end
      foreach (seq_bytes[i]) send_byte(seq_bytes[i], i == end_at);
      sent += seq_bytes.size();
    end
  endtask

  // Field extremes, every sequence length and each error kind
  task automatic test_directed();
    logic [8:0] dir_q[$];
    send_idle_pct = 0;
    recv_idle_pct = 0;
    dir_q = {9'h000, 9'h07F,                       // ASCII extremes
             9'h0C2, 9'h080,                       // smallest two-byte
             9'h0EF, 9'h0BF, 9'h0BF,               // largest BMP unit
             9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,       // largest code point, ends stream
             9'h080, 9'h0FF,                       // bad lead bytes
             9'h0E2, 9'h0C2,                       // lead where a continuation belongs
             9'h0ED, 9'h0A0, 9'h080,               // surrogate
             9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,       // above the code point range
             9'h0C0, 9'h080,                       // overlong
             9'h0E2, 9'h182};                      // stream ends mid-sequence
    foreach (dir_q[i]) send_byte(dir_q[i][7:0], dir_q[i][8]);
    wait_results_drained();
  endtask

  task automatic test_mixed_traffic(input int unsigned n_items, input int unsigned src_pct,
                                    input int unsigned sink_pct);
    send_idle_pct = src_pct;
    recv_idle_pct = sink_pct;
    send_random_stream(n_items);
    wait_results_drained();
  endtask

  // Hold the output off while bytes keep coming so the input stalls
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = hold_req + 1;
    send_random_stream(80);
    wait_results_drained();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_mixed_traffic(520, 14, 68);
    test_mixed_traffic(520, 68, 14);
    test_output_backpressure();
    test_mixed_traffic(520, 0, 0);

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
